[src/bla_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and default sizes of the banded local alignment unit
// no dependencies

package bla_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned MAX_LEN_DEF = 32;
  localparam int unsigned SCORE_WIDTH_DEF = 16;

  // fixed field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned BEST_W = 13;
  localparam int unsigned PEN_W = 8;
  localparam int unsigned BAND_W = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ONE = 2'd0,
    CMD_LOAD_TWO = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_NONE     = 2'd3
  } command_e;

  // alignment column kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DIAG    = 2'd0,
    KIND_GAP_TWO = 2'd1,
    KIND_GAP_ONE = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH    = 3'd0,
    REG_MISMATCH = 3'd1,
    REG_GAP_OPEN = 3'd2,
    REG_GAP_EXT  = 3'd3,
    REG_BAND     = 3'd4
  } cfg_reg_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL_RD,
    ST_CELL_CALC,
    ST_TB_RD,
    ST_TB_STEP,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic run_start;
    logic row_skip;
    logic row_begin;
    logic mem_rd;
    logic tb_mode;
    logic cell_calc;
    logic tb_init;
    logic tb_step;
    logic out_load;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_over;
    logic row_empty;
    logic cell_last;
    logic tb_stop;
    logic out_free;
    logic out_last;
  } dp_status_t;

endpackage

[src/bla_if.sv]
`timescale 1ns / 1ps
// input and output channel interfaces with valid/ready handshake
// depends on bla_pkg

interface bla_in_if;
  logic                        valid;
  logic                        ready;
  logic [bla_pkg::CMD_W-1:0]   command;
  logic [bla_pkg::SYM_W-1:0]   symbol;

  modport source (output valid, command, symbol, input ready);
  modport sink (input valid, command, symbol, output ready);
endinterface

interface bla_out_if;
  logic                        valid;
  logic                        ready;
  logic [bla_pkg::KIND_W-1:0]  col_kind;
  logic [bla_pkg::SYM_W-1:0]   first_symbol;
  logic [bla_pkg::SYM_W-1:0]   second_symbol;
  logic                        is_match;
  logic [bla_pkg::BEST_W-1:0]  best_score;
  logic [bla_pkg::POS_W-1:0]   start_one;
  logic [bla_pkg::POS_W-1:0]   end_one;
  logic [bla_pkg::POS_W-1:0]   start_two;
  logic [bla_pkg::POS_W-1:0]   end_two;
  logic                        last;

  modport source (output valid, col_kind, first_symbol, second_symbol, is_match,
                  best_score, start_one, end_one, start_two, end_two, last,
                  input ready);
  modport sink (input valid, col_kind, first_symbol, second_symbol, is_match,
                best_score, start_one, end_one, start_two, end_two, last,
                output ready);
endinterface

[src/bla_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine: sequences band fill, traceback and column emission
// depends on bla_pkg

module bla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic                 in_run_i,
  input  bla_pkg::dp_status_t  status_i,
  output bla_pkg::ctrl_cmd_t   cmd_o,
  output logic                 idle_o
);

  bla_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bla_pkg::ST_IDLE: begin
        if (in_fire_i && in_run_i) state_d = bla_pkg::ST_ROW;
      end
      bla_pkg::ST_ROW: begin
        if (status_i.fill_over) state_d = bla_pkg::ST_TB_RD;
        else if (!status_i.row_empty) state_d = bla_pkg::ST_CELL_RD;
      end
      bla_pkg::ST_CELL_RD: state_d = bla_pkg::ST_CELL_CALC;
      bla_pkg::ST_CELL_CALC: begin
        state_d = status_i.cell_last ? bla_pkg::ST_ROW : bla_pkg::ST_CELL_RD;
      end
      bla_pkg::ST_TB_RD: state_d = bla_pkg::ST_TB_STEP;
      bla_pkg::ST_TB_STEP: begin
        state_d = status_i.tb_stop ? bla_pkg::ST_OUT_RD : bla_pkg::ST_TB_RD;
      end
      bla_pkg::ST_OUT_RD: state_d = bla_pkg::ST_OUT_LD;
      bla_pkg::ST_OUT_LD: begin
        if (status_i.out_free) begin
          state_d = status_i.out_last ? bla_pkg::ST_IDLE : bla_pkg::ST_OUT_RD;
        end
      end
      default: state_d = bla_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bla_pkg::ST_IDLE: cmd_o.run_start = in_fire_i && in_run_i;
      bla_pkg::ST_ROW: begin
        if (status_i.fill_over) cmd_o.tb_init = 1'b1;
        else if (status_i.row_empty) cmd_o.row_skip = 1'b1;
        else cmd_o.row_begin = 1'b1;
      end
      bla_pkg::ST_CELL_RD: cmd_o.mem_rd = 1'b1;
      bla_pkg::ST_CELL_CALC: cmd_o.cell_calc = 1'b1;
      bla_pkg::ST_TB_RD: begin
        cmd_o.mem_rd  = 1'b1;
        cmd_o.tb_mode = 1'b1;
      end
      bla_pkg::ST_TB_STEP: cmd_o.tb_step = 1'b1;
      bla_pkg::ST_OUT_RD: cmd_o = '0;
      bla_pkg::ST_OUT_LD: cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign idle_o = (state_q == bla_pkg::ST_IDLE);

endmodule

[src/bla_datapath.sv]
`timescale 1ns / 1ps
// datapath: sequence stores, score memories, cell update, traceback and output register
// depends on bla_pkg

module bla_datapath #(
  parameter int unsigned MAX_LEN = bla_pkg::MAX_LEN_DEF,
  parameter int unsigned SCORE_W = bla_pkg::SCORE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bla_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bla_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_fire_i,
  input  logic [bla_pkg::CMD_W-1:0]         command_i,
  input  logic [bla_pkg::SYM_W-1:0]         symbol_i,
  input  bla_pkg::ctrl_cmd_t                cmd_i,
  output bla_pkg::dp_status_t               status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [bla_pkg::KIND_W-1:0]        col_kind_o,
  output logic [bla_pkg::SYM_W-1:0]         first_symbol_o,
  output logic [bla_pkg::SYM_W-1:0]         second_symbol_o,
  output logic                              is_match_o,
  output logic [bla_pkg::BEST_W-1:0]        best_score_o,
  output logic [bla_pkg::POS_W-1:0]         start_one_o,
  output logic [bla_pkg::POS_W-1:0]         end_one_o,
  output logic [bla_pkg::POS_W-1:0]         start_two_o,
  output logic [bla_pkg::POS_W-1:0]         end_two_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN + 2);
  localparam int unsigned SEQ_AW = $clog2(MAX_LEN);
  localparam int unsigned DIM = MAX_LEN + 1;
  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CELL_AW = $clog2(CELLS);
  localparam int unsigned TRACE_DEPTH = 2 * MAX_LEN;
  localparam int unsigned TR_AW = $clog2(TRACE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TRACE_DEPTH + 1);
  localparam int unsigned DIFF_W =
      ((IDX_W > bla_pkg::BAND_W) ? IDX_W : bla_pkg::BAND_W) + 2;

  localparam logic signed [DIFF_W-1:0] ONE_D = DIFF_W'(1);
  localparam logic signed [SCORE_W-1:0] ZERO_S = '0;

  typedef struct packed {
    logic [bla_pkg::KIND_W-1:0] kind;
    logic [bla_pkg::SYM_W-1:0]  a;
    logic [bla_pkg::SYM_W-1:0]  b;
  } trace_t;

  // configuration registers
  logic [bla_pkg::PEN_W-1:0]  match_q, mism_q, gopen_q, gext_q;
  logic [bla_pkg::BAND_W-1:0] band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 8'd2;
      mism_q  <= 8'd1;
      gopen_q <= 8'd2;
      gext_q  <= 8'd1;
      band_q  <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bla_pkg::REG_MATCH:    match_q <= cfg_data_i;
        bla_pkg::REG_MISMATCH: mism_q  <= cfg_data_i;
        bla_pkg::REG_GAP_OPEN: gopen_q <= cfg_data_i;
        bla_pkg::REG_GAP_EXT:  gext_q  <= cfg_data_i;
        bla_pkg::REG_BAND:     band_q  <= cfg_data_i[bla_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  logic [IDX_W-1:0] len1_q, len2_q, i_q, j_q, best_row_q, best_col_q;
  logic [CNT_W-1:0] count_q, ptr_q;
  logic signed [SCORE_W-1:0] best_q, hleft_q, fleft_q;
  logic out_valid_q;

  // sequence stores and score memories
  logic [bla_pkg::SYM_W-1:0] seq1_mem [MAX_LEN];
  logic [bla_pkg::SYM_W-1:0] seq2_mem [MAX_LEN];
  logic signed [SCORE_W-1:0] h_mem [CELLS];
  logic signed [SCORE_W-1:0] e_mem [CELLS];
  trace_t trace_mem [TRACE_DEPTH];

  // registered read data
  logic signed [SCORE_W-1:0] ha_q, hb_q, ea_q;
  logic va_q, vb_q;
  logic [bla_pkg::SYM_W-1:0] sym1_q, sym2_q;
  trace_t trace_rd_q;

  // band geometry
  logic signed [DIFF_W-1:0] i_s, j_s, n1_s, n2_s, bw_s, js_raw, js, je_raw, je;
  assign i_s  = DIFF_W'(i_q);
  assign j_s  = DIFF_W'(j_q);
  assign n1_s = DIFF_W'(len1_q);
  assign n2_s = DIFF_W'(len2_q);
  assign bw_s = DIFF_W'(band_q);
  assign js_raw = i_s - bw_s;
  assign js     = (js_raw < ONE_D) ? ONE_D : js_raw;
  assign je_raw = i_s + bw_s;
  assign je     = (je_raw > n2_s) ? n2_s : je_raw;

  // read addresses: up / current cell on port a, diagonal on port b
  logic signed [DIFF_W-1:0] ra, ca, rb, cb;
  logic va, vb;
  logic [CELL_AW-1:0] addr_a, addr_b, addr_w;
  assign ra = cmd_i.tb_mode ? i_s : i_s - ONE_D;
  assign ca = j_s;
  assign rb = i_s - ONE_D;
  assign cb = j_s - ONE_D;
  assign va = (ra >= ONE_D) && (ca >= ONE_D) && (ra <= n1_s) && (ca <= n2_s) &&
              (ca - ra <= bw_s) && (ra - ca <= bw_s);
  assign vb = (rb >= ONE_D) && (cb >= ONE_D) && (rb <= n1_s) && (cb <= n2_s) &&
              (cb - rb <= bw_s) && (rb - cb <= bw_s);
  assign addr_a = CELL_AW'(ra[IDX_W-1:0]) * CELL_AW'(DIM) + CELL_AW'(ca[IDX_W-1:0]);
  assign addr_b = CELL_AW'(rb[IDX_W-1:0]) * CELL_AW'(DIM) + CELL_AW'(cb[IDX_W-1:0]);
  assign addr_w = CELL_AW'(i_q) * CELL_AW'(DIM) + CELL_AW'(j_q);

  // sequence loads
  logic wr_one, wr_two;
  assign wr_one = in_fire_i && (command_i == bla_pkg::CMD_LOAD_ONE) &&
                  (len1_q < IDX_W'(MAX_LEN));
  assign wr_two = in_fire_i && (command_i == bla_pkg::CMD_LOAD_TWO) &&
                  (len2_q < IDX_W'(MAX_LEN));

  always_ff @(posedge clk_i) begin
    if (wr_one) seq1_mem[len1_q[SEQ_AW-1:0]] <= symbol_i;
    if (wr_two) seq2_mem[len2_q[SEQ_AW-1:0]] <= symbol_i;
    if (cmd_i.mem_rd) begin
      sym1_q <= seq1_mem[rb[SEQ_AW-1:0]];
      sym2_q <= seq2_mem[cb[SEQ_AW-1:0]];
    end
  end

  // masked scores: cells outside the band or the sequences read as zero
  logic signed [SCORE_W-1:0] ha_v, hb_v, ea_v;
  assign ha_v = va_q ? ha_q : ZERO_S;
  assign hb_v = vb_q ? hb_q : ZERO_S;
  assign ea_v = va_q ? ea_q : ZERO_S;

  // cell update
  logic signed [SCORE_W-1:0] ms_s, mm_s, go_s, ge_s, sub_s;
  logic signed [SCORE_W-1:0] e_up, e_in, f_up, f_in, e_new, f_new, d_new, ef, hd, h_new;
  assign ms_s = SCORE_W'(match_q);
  assign mm_s = SCORE_W'(mism_q);
  assign go_s = SCORE_W'(gopen_q);
  assign ge_s = SCORE_W'(gext_q);
  assign sub_s = (sym1_q == sym2_q) ? ms_s : -mm_s;
  assign e_up  = ha_v - go_s;
  assign e_in  = ea_v - ge_s;
  assign e_new = (e_up > e_in) ? e_up : e_in;
  assign f_up  = hleft_q - go_s;
  assign f_in  = fleft_q - ge_s;
  assign f_new = (f_up > f_in) ? f_up : f_in;
  assign d_new = hb_v + sub_s;
  assign ef    = (e_new > f_new) ? e_new : f_new;
  assign hd    = (d_new > ef) ? d_new : ef;
  assign h_new = (hd > ZERO_S) ? hd : ZERO_S;

  // score memories: two reads on h, one on e, one write each
  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_calc) begin
      h_mem[addr_w] <= h_new;
      e_mem[addr_w] <= e_new;
    end
    if (cmd_i.mem_rd) begin
      ha_q <= h_mem[addr_a];
      hb_q <= h_mem[addr_b];
      ea_q <= e_mem[addr_a];
      va_q <= va;
      vb_q <= vb;
    end
  end

  // traceback decision
  logic tb_stop, diag_ok, gap_ok;
  trace_t tb_col;
  assign tb_stop = !(ha_v > ZERO_S) || (count_q == CNT_W'(TRACE_DEPTH));
  assign diag_ok = (ha_v == d_new);
  assign gap_ok  = (ha_v == ea_v);
  always_comb begin
    tb_col.kind = diag_ok ? bla_pkg::KIND_DIAG :
                  (gap_ok ? bla_pkg::KIND_GAP_TWO : bla_pkg::KIND_GAP_ONE);
    tb_col.a = (tb_col.kind == bla_pkg::KIND_GAP_ONE) ? '0 : sym1_q;
    tb_col.b = (tb_col.kind == bla_pkg::KIND_GAP_TWO) ? '0 : sym2_q;
  end

  // trace buffer, read back in reverse
  logic [CNT_W-1:0] ptr_m1;
  assign ptr_m1 = ptr_q - CNT_W'(1);
  always_ff @(posedge clk_i) begin
    if (cmd_i.tb_step && !tb_stop) trace_mem[count_q[TR_AW-1:0]] <= tb_col;
    trace_rd_q <= trace_mem[ptr_m1[TR_AW-1:0]];
  end

  logic out_free, out_last, cell_last;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_last  = (ptr_q <= CNT_W'(1));
  assign cell_last = (j_s == je);

  // sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q <= '0;
      len2_q <= '0;
      i_q <= '0;
      j_q <= '0;
      best_q <= '0;
      best_row_q <= '0;
      best_col_q <= '0;
      hleft_q <= '0;
      fleft_q <= '0;
      count_q <= '0;
      ptr_q <= '0;
    end else begin
      if (wr_one) len1_q <= len1_q + IDX_W'(1);
      if (wr_two) len2_q <= len2_q + IDX_W'(1);
      if (cmd_i.run_start) begin
        i_q <= IDX_W'(1);
        best_q <= '0;
        best_row_q <= '0;
        best_col_q <= '0;
      end
      if (cmd_i.row_skip) i_q <= i_q + IDX_W'(1);
      if (cmd_i.row_begin) begin
        j_q <= js[IDX_W-1:0];
        hleft_q <= '0;
        fleft_q <= '0;
      end
      if (cmd_i.cell_calc) begin
        hleft_q <= h_new;
        fleft_q <= f_new;
        if (h_new > best_q) begin
          best_q <= h_new;
          best_row_q <= i_q;
          best_col_q <= j_q;
        end
        if (cell_last) i_q <= i_q + IDX_W'(1);
        else j_q <= j_q + IDX_W'(1);
      end
      if (cmd_i.tb_init) begin
        i_q <= best_row_q;
        j_q <= best_col_q;
        count_q <= '0;
      end
      if (cmd_i.tb_step) begin
        if (tb_stop) begin
          ptr_q <= count_q;
        end else begin
          count_q <= count_q + CNT_W'(1);
          if (tb_col.kind != bla_pkg::KIND_GAP_ONE) i_q <= i_q - IDX_W'(1);
          if (tb_col.kind != bla_pkg::KIND_GAP_TWO) j_q <= j_q - IDX_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        if (ptr_q != '0) ptr_q <= ptr_m1;
        if (out_last) begin
          len1_q <= '0;
          len2_q <= '0;
        end
      end
    end
  end

  // output register
  logic [bla_pkg::KIND_W-1:0] kind_q;
  logic [bla_pkg::SYM_W-1:0]  a_q, b_q;
  logic                       match_o_q, last_q;
  logic [bla_pkg::BEST_W-1:0] best_o_q;
  logic [bla_pkg::POS_W-1:0]  s1_q, e1_q, s2_q, e2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_q <= out_last;
      if (ptr_q == '0) begin
        kind_q    <= bla_pkg::KIND_EMPTY;
        a_q       <= '0;
        b_q       <= '0;
        match_o_q <= 1'b0;
        best_o_q  <= '0;
        s1_q      <= '0;
        e1_q      <= '0;
        s2_q      <= '0;
        e2_q      <= '0;
      end else begin
        kind_q    <= trace_rd_q.kind;
        a_q       <= trace_rd_q.a;
        b_q       <= trace_rd_q.b;
        match_o_q <= (trace_rd_q.kind == bla_pkg::KIND_DIAG) &&
                     (trace_rd_q.a == trace_rd_q.b);
        best_o_q  <= best_q[bla_pkg::BEST_W-1:0];
        s1_q      <= bla_pkg::POS_W'(i_q);
        e1_q      <= bla_pkg::POS_W'(best_row_q);
        s2_q      <= bla_pkg::POS_W'(j_q);
        e2_q      <= bla_pkg::POS_W'(best_col_q);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign col_kind_o      = kind_q;
  assign first_symbol_o  = a_q;
  assign second_symbol_o = b_q;
  assign is_match_o      = match_o_q;
  assign best_score_o    = best_o_q;
  assign start_one_o     = s1_q;
  assign end_one_o       = e1_q;
  assign start_two_o     = s2_q;
  assign end_two_o       = e2_q;
  assign last_o          = last_q;

  // status to controller
  assign status_o.fill_over = (i_s > n1_s);
  assign status_o.row_empty = (js > je);
  assign status_o.cell_last = cell_last;
  assign status_o.tb_stop   = tb_stop;
  assign status_o.out_free  = out_free;
  assign status_o.out_last  = out_last;

endmodule

[src/banded_local_alignment_affine_unit.sv]
`timescale 1ns / 1ps
// top level of the banded affine-gap local alignment unit
// depends on bla_pkg, bla_if, bla_ctrl, bla_datapath

// Load transactions (command 0 or 1) give no result. A run transaction fills
// the banded score matrices cell by cell, each cell through a read state on
// the score memories and then an update and write state, after a row state
// per row. It then traces back, each step a read state and then a step state,
// and emits the columns, each a read state and then a load state that waits
// until the output register is free. The score memories need no clearing
// pass: cells outside the band or beyond the loaded sequences read as zero.
// Input is taken only between runs; the last column may still wait in the
// output register.

module banded_local_alignment_affine_unit #(
  parameter int unsigned MAX_LEN     = bla_pkg::MAX_LEN_DEF,
  parameter int unsigned SCORE_WIDTH = bla_pkg::SCORE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bla_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bla_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bla_in_if.sink                          in_ch,
  bla_out_if.source                       out_ch
);

  bla_pkg::ctrl_cmd_t  cmd;
  bla_pkg::dp_status_t status;
  logic idle, in_fire;

  // input handshake
  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;

  bla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_run_i  (in_ch.command == bla_pkg::CMD_RUN),
    .status_i  (status),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  bla_datapath #(
    .MAX_LEN (MAX_LEN),
    .SCORE_W (SCORE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_fire_i       (in_fire),
    .command_i       (in_ch.command),
    .symbol_i        (in_ch.symbol),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .col_kind_o      (out_ch.col_kind),
    .first_symbol_o  (out_ch.first_symbol),
    .second_symbol_o (out_ch.second_symbol),
    .is_match_o      (out_ch.is_match),
    .best_score_o    (out_ch.best_score),
    .start_one_o     (out_ch.start_one),
    .end_one_o       (out_ch.end_one),
    .start_two_o     (out_ch.start_two),
    .end_two_o       (out_ch.end_two),
    .last_o          (out_ch.last)
  );

endmodule
